// ----- sv/modexp_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Modular exponentiation package
// Operand widths, sequencer state codes and shared types.
// ---------------------------------------------------------------------------
package modexp_pkg;

   localparam int DATA_W = 31;
   localparam int EXP_W  = 64;
   localparam int CNT_W  = $clog2(DATA_W);

   typedef logic [DATA_W-1:0] word_type;
   typedef logic [CNT_W-1:0]  count_type;
   typedef logic [2:0]        state_type;

   localparam count_type STEP_LAST = count_type'(DATA_W - 1);

   localparam state_type ST_IDLE = 3'd0;
   localparam state_type ST_RED  = 3'd1;
   localparam state_type ST_MUL  = 3'd2;
   localparam state_type ST_SQR  = 3'd3;

endpackage

// ----- sv/modular_exponentiation.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Modular exponentiation
// Right-to-left square and multiply on one bit-serial modular multiplier.
// ---------------------------------------------------------------------------
// Usage:
//   Drive req_base_value, req_exponent and req_modulus and raise start; the
//   item transfers at a clock edge where start is high and busy is low.
//   Exactly one result follows: rsp_power_result is shown for one cycle with
//   rsp_valid high, and transfers at the end of that cycle. The receiver
//   cannot stall the block; a new item may be started in the strobe cycle.
// Sequence:
//   Negative exponent or zero modulus: result in the cycle after the transfer.
//   Otherwise a multiplier pass reduces the base, then for each exponent bit up
//   to the highest set one a squaring (not after the top bit) plus a multiply
//   for every set bit, then the registered result strobe.
//   Worst case (63 set bits) is 126 multiplier passes. The modular multiplier
//   handles one multiplier bit per cycle with one shift-add and a
//   compare-subtract against the modulus and twice it.
//   busy stays high throughout; one item is in work at a time.
// Reset:
//   Synchronous, active high; returns to idle and drops any pending result.
// ---------------------------------------------------------------------------
module modular_exponentiation (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic        [modexp_pkg::DATA_W-1:0] req_base_value,
   input  logic signed [modexp_pkg::EXP_W-1:0]  req_exponent,
   input  logic        [modexp_pkg::DATA_W-1:0] req_modulus,
   output logic                                 rsp_valid,
   output logic        [modexp_pkg::DATA_W-1:0] rsp_power_result
);

   localparam int SUM_W = modexp_pkg::DATA_W + 3;

   modexp_pkg::state_type state_ff, state_in;
   modexp_pkg::word_type  acc_ff, acc_in;
   modexp_pkg::word_type  pow_ff, pow_in;
   modexp_pkg::word_type  mod_ff, mod_in;
   modexp_pkg::word_type  opa_ff, opa_in;
   modexp_pkg::word_type  opb_ff, opb_in;
   modexp_pkg::word_type  rem_ff, rem_in;
   modexp_pkg::count_type cnt_ff, cnt_in;
   logic [modexp_pkg::EXP_W-2:0] exp_ff, exp_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   modexp_pkg::word_type  rsp_result_ff, rsp_result_in;

   logic [SUM_W-1:0]             sum_t;
   logic [SUM_W-1:0]             diff1;
   logic [SUM_W-1:0]             diff2;
   modexp_pkg::word_type         step_rem;
   modexp_pkg::word_type         next_acc;
   modexp_pkg::word_type         next_pow;
   logic [modexp_pkg::EXP_W-2:0] next_exp;

   // one step of the shift-add modular multiplier
   always_comb begin
      sum_t = {2'b00, rem_ff, 1'b0}
            + (opb_ff[modexp_pkg::DATA_W-1] ? {3'b000, opa_ff} : {SUM_W{1'b0}});
      diff1 = sum_t - {3'b000, mod_ff};
      diff2 = sum_t - {2'b00, mod_ff, 1'b0};
      if (!diff2[SUM_W-1]) begin
         step_rem = diff2[modexp_pkg::DATA_W-1:0];
      end else if (!diff1[SUM_W-1]) begin
         step_rem = diff1[modexp_pkg::DATA_W-1:0];
      end else begin
         step_rem = sum_t[modexp_pkg::DATA_W-1:0];
      end
   end

   always_comb begin
      state_in      = state_ff;
      acc_in        = acc_ff;
      pow_in        = pow_ff;
      mod_in        = mod_ff;
      opa_in        = opa_ff;
      opb_in        = opb_ff;
      rem_in        = rem_ff;
      cnt_in        = cnt_ff;
      exp_in        = exp_ff;
      rsp_valid_in  = 1'b0;
      rsp_result_in = rsp_result_ff;
      next_acc      = acc_ff;
      next_pow      = pow_ff;
      next_exp      = exp_ff;

      unique case (state_ff) inside
         modexp_pkg::ST_IDLE: begin
            if (start) begin
               if (req_modulus == '0 || req_exponent[modexp_pkg::EXP_W-1]) begin
                  rsp_valid_in  = 1'b1;
                  rsp_result_in = '0;
               end else begin
                  acc_in   = (req_modulus == modexp_pkg::word_type'(1)) ?
                             '0 : modexp_pkg::word_type'(1);
                  mod_in   = req_modulus;
                  exp_in   = req_exponent[modexp_pkg::EXP_W-2:0];
                  opa_in   = modexp_pkg::word_type'(1);
                  opb_in   = req_base_value;
                  rem_in   = '0;
                  cnt_in   = modexp_pkg::STEP_LAST;
                  state_in = modexp_pkg::ST_RED;
               end
            end
         end
         modexp_pkg::ST_RED, modexp_pkg::ST_MUL, modexp_pkg::ST_SQR: begin
            rem_in = step_rem;
            opb_in = {opb_ff[modexp_pkg::DATA_W-2:0], 1'b0};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               if (state_ff == modexp_pkg::ST_MUL) begin
                  next_acc = step_rem;
               end else begin
                  next_pow = step_rem;
               end
               if (state_ff == modexp_pkg::ST_SQR) begin
                  next_exp = exp_ff >> 1;
               end
               acc_in = next_acc;
               pow_in = next_pow;
               exp_in = next_exp;
               rem_in = '0;
               cnt_in = modexp_pkg::STEP_LAST;
               // after a multiply the current bit is spent: square only if
               // higher bits remain
               if ((state_ff == modexp_pkg::ST_MUL) ?
                   (next_exp[modexp_pkg::EXP_W-2:1] == '0) : (next_exp == '0)) begin
                  rsp_valid_in  = 1'b1;
                  rsp_result_in = next_acc;
                  state_in      = modexp_pkg::ST_IDLE;
               end else if (state_ff != modexp_pkg::ST_MUL && next_exp[0]) begin
                  opa_in   = next_acc;
                  opb_in   = next_pow;
                  state_in = modexp_pkg::ST_MUL;
               end else begin
                  opa_in   = next_pow;
                  opb_in   = next_pow;
                  state_in = modexp_pkg::ST_SQR;
               end
            end
         end
         default: begin
            state_in = modexp_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= modexp_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff        <= acc_in;
      pow_ff        <= pow_in;
      mod_ff        <= mod_in;
      opa_ff        <= opa_in;
      opb_ff        <= opb_in;
      rem_ff        <= rem_in;
      cnt_ff        <= cnt_in;
      exp_ff        <= exp_in;
      rsp_result_ff <= rsp_result_in;
   end

   assign busy             = (state_ff != modexp_pkg::ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_power_result = rsp_result_ff;

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Modular exponentiation testbench
// Feeds base/exponent/modulus requests through the start/busy handshake with
// random gaps, predicts each power by square and multiply, and checks every
// strobed result in order against the oldest predicted power.
// ---------------------------------------------------------------------------
module tb;

   localparam int                   CYCLE_LIMIT = 25_000_000;
   localparam int                   DRAIN_WAIT  = 4000;
   localparam modexp_pkg::word_type MOD_PRIME   = 31'd1000000007;
   localparam modexp_pkg::word_type WORD_MAX    = {modexp_pkg::DATA_W{1'b1}};

   typedef struct {
      modexp_pkg::word_type                base;
      logic signed [modexp_pkg::EXP_W-1:0] exponent;
      modexp_pkg::word_type                modulus;
   } power_request_type;

   typedef struct {
      modexp_pkg::word_type     power;
      power_request_type        req;
   } power_expect_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                start = 1'b0;
   logic                                busy;
   modexp_pkg::word_type                req_base_value = '0;
   logic signed [modexp_pkg::EXP_W-1:0] req_exponent = '0;
   modexp_pkg::word_type                req_modulus = '0;
   logic                                rsp_valid;
   modexp_pkg::word_type                rsp_power_result;

   power_request_type           pending_requests[$];
   power_expect_type            expected_powers[$];
   power_request_type           next_req;
   power_expect_type            queued_power;
   power_expect_type            oldest_power;
   int                          gap_left = 0;
   int                          cycle_count = 0;
   int                          fail_count = 0;
   int                          requests_sent = 0;
   int                          negative_sent = 0;
   int                          long_sent = 0;
   int                          results_checked = 0;

   modular_exponentiation u_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_base_value   (req_base_value),
      .req_exponent     (req_exponent),
      .req_modulus      (req_modulus),
      .rsp_valid        (rsp_valid),
      .rsp_power_result (rsp_power_result)
   );

   always #5 clock = ~clock;

   // Right-to-left square and multiply; every product stays below 2^62.
   function automatic modexp_pkg::word_type modpow_predict(power_request_type r);
      logic [63:0]                  acc;
      logic [63:0]                  sq;
      logic [63:0]                  m64;
      logic [modexp_pkg::EXP_W-1:0] bits;
      if (r.modulus == '0 || r.exponent[modexp_pkg::EXP_W-1]) return '0;
      m64  = {33'd0, r.modulus};
      acc  = 64'd1 % m64;
      sq   = {33'd0, r.base};
      bits = r.exponent;
      while (bits != '0) begin
         if (bits[0]) acc = (acc * sq) % m64;
         sq   = (sq * sq) % m64;
         bits = bits >> 1;
      end
      return modexp_pkg::word_type'(acc);
   endfunction

   // Mostly back-to-back or short pauses, now and then a long one.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 40) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 15);
      return $urandom_range(16, 60);
   endfunction

   task automatic add_request(modexp_pkg::word_type b, logic [modexp_pkg::EXP_W-1:0] e,
                              modexp_pkg::word_type m);
      power_request_type r;
      r.base     = b;
      r.exponent = e;
      r.modulus  = m;
      pending_requests = {pending_requests, r};
   endtask

   // Driver: hold a request until it transfers, then pause or present the next.
   always @(posedge clock) begin
      if (reset) begin
         start    <= 1'b0;
         gap_left <= 0;
      end else if (!start || !busy) begin
         if (start) begin
            next_req.base      = req_base_value;
            next_req.exponent  = req_exponent;
            next_req.modulus   = req_modulus;
            queued_power.power = modpow_predict(next_req);
            queued_power.req   = next_req;
            expected_powers    = {expected_powers, queued_power};
            requests_sent++;
            if (req_exponent[modexp_pkg::EXP_W-1]) negative_sent++;
            else if (req_exponent[modexp_pkg::EXP_W-1:32] != '0) long_sent++;
         end
         if (gap_left != 0) begin
            start    <= 1'b0;
            gap_left <= gap_left - 1;
         end else if (pending_requests.size() != 0) begin
            next_req = pending_requests.pop_front();
            req_base_value <= next_req.base;
            req_exponent   <= next_req.exponent;
            req_modulus    <= next_req.modulus;
            start          <= 1'b1;
            gap_left       <= pick_gap();
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: every strobe is a transfer, compare against the oldest power.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_powers.size() == 0) begin
            $display("%0t: unexpected result %0d with nothing outstanding",
                     $time, rsp_power_result);
            fail_count++;
         end else begin
            oldest_power = expected_powers.pop_front();
            results_checked++;
            if (rsp_power_result !== oldest_power.power) begin
               $display("%0t: power_result expected %0d actual %0d (base %0d exp %0d mod %0d)",
                        $time, oldest_power.power, rsp_power_result,
                        oldest_power.req.base, oldest_power.req.exponent,
                        oldest_power.req.modulus);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timed out with %0d results outstanding", $time,
                  expected_powers.size());
         $display("modular_exponentiation: mismatch");
         $finish;
      end
   end

   initial begin
      int                           n;
      int                           len;
      int                           roll;
      logic [modexp_pkg::EXP_W-1:0] e;
      modexp_pkg::word_type         b;
      modexp_pkg::word_type         m;

      // Directed: zero/negative exponents, zero and unit modulus, field extremes.
      add_request(31'd0, 64'd0, 31'd1);
      add_request(31'd5, 64'd0, 31'd7);
      add_request(31'd0, 64'd0, 31'd7);
      add_request(31'd0, 64'd5, 31'd13);
      add_request(31'd9, {modexp_pkg::EXP_W{1'b1}}, 31'd11);
      add_request(WORD_MAX, {1'b1, {(modexp_pkg::EXP_W-1){1'b0}}}, WORD_MAX);
      add_request(31'd3, 64'd5, 31'd0);
      add_request(31'd3, 64'd0, 31'd0);
      add_request(WORD_MAX, {1'b0, {(modexp_pkg::EXP_W-1){1'b1}}}, WORD_MAX);
      add_request(WORD_MAX, {1'b0, {(modexp_pkg::EXP_W-1){1'b1}}}, WORD_MAX - 31'd1);
      add_request(WORD_MAX - 31'd1, 64'd1, WORD_MAX);
      add_request(31'd123, 64'd1, 31'd100);
      add_request(31'd2, 64'd30, WORD_MAX);
      add_request(31'd3, {1'b0, {(modexp_pkg::EXP_W-1){1'b1}}}, MOD_PRIME);
      add_request(WORD_MAX, 64'd2, WORD_MAX - 31'd1);
      add_request(31'd77, 64'h0123_4567_89ab_cdef, 31'd1);
      add_request(31'd1, 64'h7654_3210_fedc_ba98, 31'd2);
      add_request(31'd2, 64'h5555_5555_5555_5555, 31'd2147483629);
      add_request(31'd7, 64'h4000_0000_0000_0000, MOD_PRIME);
      add_request(MOD_PRIME - 31'd1, 64'd3, MOD_PRIME);
      add_request(31'h2aaa_aaaa, 64'h2aaa_aaaa_aaaa_aaaa, 31'h5555_5555);

      // Random: mostly short exponents to keep the run short, some up to 63 bits.
      for (n = 0; n < 1300; n++) begin
         roll = $urandom_range(0, 99);
         if (roll < 70)      m = modexp_pkg::word_type'($urandom_range(1, int'(WORD_MAX)));
         else if (roll < 80) m = modexp_pkg::word_type'($urandom_range(1, 16));
         else if (roll < 90) m = MOD_PRIME;
         else                m = WORD_MAX - modexp_pkg::word_type'($urandom_range(0, 255));

         roll = $urandom_range(0, 99);
         if (roll < 60)      b = modexp_pkg::word_type'($urandom);
         else if (roll < 80) b = modexp_pkg::word_type'($urandom % m);
         else if (roll < 90) b = modexp_pkg::word_type'($urandom_range(0, 1));
         else if (roll < 95) b = m - 31'd1;
         else                b = WORD_MAX;

         roll = $urandom_range(0, 99);
         e = {$urandom, $urandom};
         if (roll < 12) begin
            e[modexp_pkg::EXP_W-1] = 1'b1;
         end else if (roll < 20) begin
            e = 64'($urandom_range(0, 1));
         end else begin
            len = (roll < 80) ? $urandom_range(1, 12)
                              : $urandom_range(13, modexp_pkg::EXP_W - 1);
            e = e & ((64'd1 << len) - 64'd1);
            e[len-1] = 1'b1;
         end
         add_request(b, e, m);
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Drain: wait until every request has transferred and every result arrived.
      @(negedge clock);
      while (pending_requests.size() != 0 || start || expected_powers.size() != 0)
         @(negedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("%0d requests transferred (%0d negative exponents, %0d above 32 bits)",
               requests_sent, negative_sent, long_sent);
      $display("%0d results checked, %0d failures", results_checked, fail_count);
      if (fail_count == 0) begin
         $display("modular_exponentiation: match");
      end else begin
         $display("modular_exponentiation: mismatch");
      end
      $finish;
   end

endmodule
